@@ src/plt_pkg.sv @@
// plt_pkg: shared widths, codes and helpers for the partition label table
// no dependencies; used by partition_label_table and plt_ram
`default_nettype none

package plt_pkg;

  localparam int MAX_DIMS_DEFAULT = 32;
  localparam int LABEL_W          = 5;
  localparam int MASK_W           = 32;
  localparam int DIMS_W           = 6;
  localparam int CFG_IDX_W        = 2;

  // operation codes
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_MERGE = 2'd1;
  localparam logic [1:0] OP_SPLIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SAME      = 2'd1;
  localparam logic [1:0] ST_BAD_SPLIT = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT = 2'd1;

  // position of the lowest set bit, zero for an empty mask
  function automatic logic [LABEL_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
    logic [LABEL_W-1:0] pos;
    pos = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) pos = LABEL_W'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

@@ src/partition_label_table.sv @@
// partition_label_table: label table partition keeper with merge and split
// depends on plt_pkg and plt_ram
//
//   channel | signals                      | transfer when
//   in      | in_valid/in_ready, op..masks | in_valid && in_ready
//   out     | out_valid/out_ready, results | out_valid && out_ready
//   cfg     | cfg_valid/cfg_ready, idx/dat | cfg_valid && cfg_ready
//
// an item runs a lookup of three entries, then one read-modify-write pass over the
// active entries of the table memory; a split with well-formed masks adds a check pass
// reset and every write to CFG_DIMS or CFG_INIT start a fill pass over all MAX_DIMS entries, no input taken
// the result sits in an output register; the next item is taken while it waits
// a finished item stalls in its last state only while the output register is full
`default_nettype none

module partition_label_table #(
  parameter int MAX_DIMS = plt_pkg::MAX_DIMS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        op,
  input  wire logic [plt_pkg::LABEL_W-1:0]       dim_a,
  input  wire logic [plt_pkg::LABEL_W-1:0]       dim_b,
  input  wire logic [plt_pkg::LABEL_W-1:0]       label_query,
  input  wire logic [plt_pkg::MASK_W-1:0]        mask_first,
  input  wire logic [plt_pkg::MASK_W-1:0]        mask_second,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [plt_pkg::LABEL_W-1:0]       label_a,
  output logic      [plt_pkg::LABEL_W-1:0]       label_b,
  output logic                                   same_group,
  output logic      [plt_pkg::MASK_W-1:0]        members_mask,
  output logic      [plt_pkg::MASK_W-1:0]        labels_in_use,
  output logic      [1:0]                        status,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [plt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [plt_pkg::DIMS_W-1:0]        cfg_data
);

  localparam int IDX_W      = $clog2(MAX_DIMS);
  localparam int ACTIVE_CAP = (MAX_DIMS < 32) ? MAX_DIMS : 32;
  localparam int LW         = plt_pkg::LABEL_W;
  localparam int MW         = plt_pkg::MASK_W;
  localparam int DW         = plt_pkg::DIMS_W;

  typedef enum logic [2:0] {
    S_FILL, S_IDLE, S_LOOK, S_CHECK, S_PASS, S_FINISH
  } state_t;

  state_t           state;
  logic [DW-1:0]    dims_in_use;
  logic             init_singletons;
  logic [IDX_W-1:0] fill_idx;
  logic [1:0]       lk;
  logic [DW-1:0]    scan;
  logic             dv;
  logic [LW-1:0]    pos;

  // latched item
  logic [1:0]       r_op;
  logic [LW-1:0]    r_a, r_b, r_q;
  logic [MW-1:0]    r_m1, r_m2;
  logic [LW-1:0]    l1, l2;
  logic             a_ok, b_ok, pre_ok;

  // lookup results and pass control
  logic [LW-1:0]    la_old, lb_old, lc_old;
  logic             do_merge, do_split, mismatch;
  logic [LW-1:0]    keep, drop;
  logic [LW-1:0]    cap_la, cap_lb;
  logic [MW-1:0]    acc_members, acc_used;
  logic [1:0]       st;

  // ram ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0]    ram_wdata, ram_rdata;
  logic [LW-1:0]    new_val;

  // active count and mask
  logic [DW-1:0]    n_act;
  logic [MW-1:0]    act_mask;
  logic [MW-1:0]    split_union;
  logic             in_xfer, cfg_xfer, cfg_hit, scan_more, pass_end;

  // nothing is taken while reset is held
  assign in_ready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == plt_pkg::CFG_DIMS) || (cfg_index == plt_pkg::CFG_INIT);

  always_comb begin
    if (dims_in_use == '0) begin
      n_act = DW'(1);
    end else if (dims_in_use > DW'(ACTIVE_CAP)) begin
      n_act = DW'(ACTIVE_CAP);
    end else begin
      n_act = dims_in_use;
    end
    if (n_act >= DW'(MW)) begin
      act_mask = '1;
    end else begin
      act_mask = (MW'(1) << n_act) - MW'(1);
    end
  end

  assign split_union = r_m1 | r_m2;
  assign scan_more   = (scan < n_act);
  assign pass_end    = !scan_more && !dv;

  // relabel of the entry coming out of the memory
  always_comb begin
    if (do_merge && (ram_rdata == drop)) begin
      new_val = keep;
    end else if (do_split && r_m1[pos]) begin
      new_val = l1;
    end else if (do_split && r_m2[pos]) begin
      new_val = l2;
    end else begin
      new_val = ram_rdata;
    end
  end

  // memory access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(pos);
    ram_wdata = new_val;
    ram_re    = 1'b0;
    ram_raddr = IDX_W'(scan);
    case (state)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx;
        ram_wdata = init_singletons ? LW'(fill_idx) : '0;
      end
      S_LOOK: begin
        ram_re = (lk != 2'd3);
        case (lk)
          2'd0:    ram_raddr = a_ok ? IDX_W'(r_a) : '0;
          2'd1:    ram_raddr = b_ok ? IDX_W'(r_b) : '0;
          default: ram_raddr = pre_ok ? IDX_W'(l1) : '0;
        endcase
      end
      S_CHECK: begin
        ram_re = scan_more;
      end
      S_PASS: begin
        ram_re = scan_more;
        ram_we = dv && (do_merge || do_split);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  plt_ram #(
    .DEPTH  (MAX_DIMS),
    .ADDR_W (IDX_W),
    .DATA_W (LW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      r_op   <= op;
      r_a    <= dim_a;
      r_b    <= dim_b;
      r_q    <= label_query;
      r_m1   <= mask_first;
      r_m2   <= mask_second;
      l1     <= plt_pkg::lowest_bit(mask_first);
      l2     <= plt_pkg::lowest_bit(mask_second);
      a_ok   <= {1'b0, dim_a} < n_act;
      b_ok   <= {1'b0, dim_b} < n_act;
      pre_ok <= (mask_first != '0) && (mask_second != '0) &&
                ((mask_first & mask_second) == '0) &&
                ((mask_first & ~act_mask) == '0) && ((mask_second & ~act_mask) == '0);
    end
  end

  // sequencer, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_FILL;
      dims_in_use     <= DW'(32);
      init_singletons <= 1'b1;
      fill_idx        <= '0;
      out_valid       <= 1'b0;
      dv              <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          fill_idx <= fill_idx + IDX_W'(1);
          if (fill_idx == IDX_W'(MAX_DIMS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_LOOK;
            lk    <= 2'd0;
          end
        end
        S_LOOK: begin
          lk <= lk + 2'd1;
          if (lk == 2'd1) la_old <= ram_rdata;
          if (lk == 2'd2) lb_old <= ram_rdata;
          if (lk == 2'd3) begin
            lc_old      <= ram_rdata;
            scan        <= '0;
            dv          <= 1'b0;
            mismatch    <= 1'b0;
            do_merge    <= 1'b0;
            do_split    <= 1'b0;
            keep        <= (la_old < lb_old) ? la_old : lb_old;
            drop        <= (la_old < lb_old) ? lb_old : la_old;
            cap_la      <= '0;
            cap_lb      <= '0;
            acc_members <= '0;
            acc_used    <= '0;
            st          <= plt_pkg::ST_OK;
            if (r_op == plt_pkg::OP_SPLIT) begin
              if (pre_ok) begin
                state <= S_CHECK;
              end else begin
                st    <= plt_pkg::ST_BAD_SPLIT;
                state <= S_PASS;
              end
            end else if (!a_ok || !b_ok) begin
              st    <= plt_pkg::ST_RANGE;
              state <= S_PASS;
            end else if (r_op == plt_pkg::OP_MERGE) begin
              if (la_old == lb_old) begin
                st <= plt_pkg::ST_SAME;
              end else begin
                do_merge <= 1'b1;
              end
              state <= S_PASS;
            end else begin
              state <= S_PASS;
            end
          end
        end
        S_CHECK: begin
          // the split must cover exactly the group of the lowest first-part member
          dv  <= scan_more;
          pos <= LW'(scan);
          if (scan_more) scan <= scan + DW'(1);
          if (dv && (split_union[pos] != (ram_rdata == lc_old))) begin
            mismatch <= 1'b1;
          end
          if (pass_end) begin
            scan <= '0;
            if (mismatch) begin
              st <= plt_pkg::ST_BAD_SPLIT;
            end else begin
              do_split <= 1'b1;
            end
            state <= S_PASS;
          end
        end
        S_PASS: begin
          // relabel, write back, and gather results from the new labels
          dv  <= scan_more;
          pos <= LW'(scan);
          if (scan_more) scan <= scan + DW'(1);
          if (dv) begin
            if (pos == r_a) cap_la <= new_val;
            if (pos == r_b) cap_lb <= new_val;
            acc_members[pos]  <= (new_val == r_q);
            acc_used[new_val] <= 1'b1;
          end
          if (pass_end) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            label_a       <= a_ok ? cap_la : '0;
            label_b       <= b_ok ? cap_lb : '0;
            same_group    <= a_ok && b_ok && (cap_la == cap_lb);
            members_mask  <= acc_members;
            labels_in_use <= acc_used;
            status        <= st;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a write to CFG_DIMS or CFG_INIT re-initializes the table
      if (cfg_xfer) begin
        if (cfg_index == plt_pkg::CFG_DIMS) dims_in_use <= cfg_data;
        if (cfg_index == plt_pkg::CFG_INIT) init_singletons <= cfg_data[0];
        if (cfg_hit) begin
          state    <= S_FILL;
          fill_idx <= '0;
        end
      end
    end
  end

  // checks
  a_no_input_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !in_ready)
    else $error("input taken during table fill");

  a_write_only_when_owned: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_FILL || state == S_PASS))
    else $error("table written outside fill or relabel pass");

  a_same_group_labels: assert property (@(posedge clk) disable iff (rst)
    (out_valid && same_group) |-> (label_a == label_b))
    else $error("same group reported with different labels");

  a_range_label_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == plt_pkg::ST_RANGE) |-> (label_a == '0 || label_b == '0))
    else $error("range status without an inactive dimension");

endmodule

`default_nettype wire

@@ src/plt_ram.sv @@
// plt_ram: label table storage, one write port and one registered read port
// depends on plt_pkg for the default label width
`default_nettype none

module plt_ram #(
  parameter int DEPTH  = plt_pkg::MAX_DIMS_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = plt_pkg::LABEL_W
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
